// ===== sv/lfs_pkg.sv =====
// shared types, constants and helpers of the line follow steering block
package lfs_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int NSENS           = 5;
   localparam int DEPTH           = 5;
   localparam int SLOT_W          = 3;
   localparam int MAJORITY        = (DEPTH + 1) / 2;
   localparam int THR_W           = 12;
   localparam int SPEED_W         = 8;
   localparam int ERR_W           = 3;
   localparam int SUM_W           = SPEED_W + 1;
   localparam int PROD_W          = SPEED_W + SUM_W;
   localparam int MAG_W           = PROD_W + 1;
   localparam int DIV_SHIFT       = 26;
   localparam int RECIP_W         = 19;
   localparam int QUO_W           = MAG_W + RECIP_W - DIV_SHIFT;
   localparam int SPD_EXT_W       = SPEED_W + 2;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   // ceil(2**26 / 220): exact quotient for every magnitude below 2**18
   localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(305041);

   localparam int SENS_FAR_LEFT  = 0;
   localparam int SENS_LEFT      = 1;
   localparam int SENS_RIGHT     = 3;
   localparam int SENS_FAR_RIGHT = 4;

   localparam logic [THR_W-1:0]   THRESHOLD_RST  = THR_W'(1500);
   localparam logic [SPEED_W-1:0] BASE_LEFT_RST  = SPEED_W'(200);
   localparam logic [SPEED_W-1:0] BASE_RIGHT_RST = SPEED_W'(200);
   localparam logic [SPEED_W-1:0] GAIN_RST       = SPEED_W'(60);
   localparam logic [SPEED_W-1:0] SEARCH_FAST    = SPEED_W'(120);
   localparam logic [SPEED_W-1:0] SEARCH_SLOW    = SPEED_W'(60);
   localparam logic [SPEED_W-1:0] SPEED_MAX      = SPEED_W'(255);

   localparam logic signed [ERR_W-1:0] ERR_FAR_LEFT  = ERR_W'(-2);
   localparam logic signed [ERR_W-1:0] ERR_LEFT      = ERR_W'(-1);
   localparam logic signed [ERR_W-1:0] ERR_NONE      = ERR_W'(0);
   localparam logic signed [ERR_W-1:0] ERR_RIGHT     = ERR_W'(1);
   localparam logic signed [ERR_W-1:0] ERR_FAR_RIGHT = ERR_W'(2);

   typedef enum logic [1:0] {
      REG_THRESHOLD,
      REG_BASE_LEFT,
      REG_BASE_RIGHT,
      REG_GAIN
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [THR_W-1:0]   threshold;
      logic [SPEED_W-1:0] base_left;
      logic [SPEED_W-1:0] base_right;
      logic [SPEED_W-1:0] gain;
   } cfg_type;

   typedef struct packed {
      logic hist_wr;
      logic mark_en;
      logic div_en;
      logic out_load;
   } cmd_type;

   function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [SPD_EXT_W-1:0] v);
      logic [SPEED_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({2'b00, SPEED_MAX})) begin
         r = SPEED_MAX;
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/lfs_req_if.sv =====
// input channel: one set of five sensor samples per beat
interface lfs_req_if
   import lfs_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] far_left_sample;
   logic [SAMPLE_BITS-1:0] left_sample;
   logic [SAMPLE_BITS-1:0] centre_sample;
   logic [SAMPLE_BITS-1:0] right_sample;
   logic [SAMPLE_BITS-1:0] far_right_sample;

   modport source (
      output valid, far_left_sample, left_sample, centre_sample, right_sample,
             far_right_sample,
      input  ready
   );
   modport sink (
      input  valid, far_left_sample, left_sample, centre_sample, right_sample,
             far_right_sample,
      output ready
   );
endinterface

// ===== sv/lfs_rsp_if.sv =====
// result channel: motor speeds, line lost flag and position error per beat
interface lfs_rsp_if
   import lfs_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [SPEED_W-1:0]        left_speed;
   logic [SPEED_W-1:0]        right_speed;
   logic                      line_lost;
   logic signed [ERR_W-1:0]   steer_error;

   modport source (
      output valid, left_speed, right_speed, line_lost, steer_error,
      input  ready
   );
   modport sink (
      input  valid, left_speed, right_speed, line_lost, steer_error,
      output ready
   );
endinterface

// ===== sv/lfs_csr.sv =====
// configuration registers behind the apb port
module lfs_csr
   import lfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);
   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (idx)
         REG_THRESHOLD: begin
            prdata = CSR_DATA_W'(cfg_ff.threshold);
            if (wr_en) cfg_in.threshold = pwdata[THR_W-1:0];
         end
         REG_BASE_LEFT: begin
            prdata = CSR_DATA_W'(cfg_ff.base_left);
            if (wr_en) cfg_in.base_left = pwdata[SPEED_W-1:0];
         end
         REG_BASE_RIGHT: begin
            prdata = CSR_DATA_W'(cfg_ff.base_right);
            if (wr_en) cfg_in.base_right = pwdata[SPEED_W-1:0];
         end
         REG_GAIN: begin
            prdata = CSR_DATA_W'(cfg_ff.gain);
            if (wr_en) cfg_in.gain = pwdata[SPEED_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= THRESHOLD_RST;
         cfg_ff.base_left  <= BASE_LEFT_RST;
         cfg_ff.base_right <= BASE_RIGHT_RST;
         cfg_ff.gain       <= GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ===== sv/lfs_ctrl.sv =====
// sequencer: accept, mark, divide, finish; owns the result valid
module lfs_ctrl
   import lfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);
   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.hist_wr = req_valid;
            if (req_valid) state_in = ST_MARK;
         end
         ST_MARK: begin
            cmd.mark_en = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            // wait here while the previous result is still unclaimed
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an unclaimed beat");

   a_accept_mark: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MARK))
      else $error("accepted beat not followed by mark step");

   a_mark_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |=> (state_ff == ST_DIV))
      else $error("mark step not followed by divide step");

   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result valid raised outside finish step");
endmodule

// ===== sv/lfs_dp.sv =====
// datapath: sample history, majority marks, error, turn and speeds
module lfs_dp
   import lfs_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  cfg_type                 cfg,
   input  logic [SAMPLE_BITS-1:0]  samples [NSENS],
   output logic [SPEED_W-1:0]      left_speed,
   output logic [SPEED_W-1:0]      right_speed,
   output logic                    line_lost,
   output logic signed [ERR_W-1:0] steer_error
);
   localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [SAMPLE_BITS-1:0]  hist_ff [NSENS][DEPTH];
   logic [SLOT_W-1:0]       slot_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic signed [ERR_W-1:0] err_in;
   logic signed [ERR_W-1:0] last_err_ff;
   logic                    lost_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [QUO_W-1:0]        quo_ff;
   logic [SPEED_W-1:0]      left_ff;
   logic [SPEED_W-1:0]      right_ff;
   logic                    lost_out_ff;
   logic signed [ERR_W-1:0] err_out_ff;

   logic [CNT_W-1:0]             cnt [NSENS];
   logic [NSENS-1:0]             mark;
   logic [SUM_W-1:0]             base_sum;
   logic [MAG_W-1:0]             mag;
   logic [MAG_W+RECIP_W-1:0]     scaled;
   logic [SPEED_W-1:0]           turn_cap;
   logic [SPEED_W-1:0]           turn;
   logic signed [SPD_EXT_W-1:0]  ls_ext;
   logic signed [SPD_EXT_W-1:0]  rs_ext;
   logic [SPEED_W-1:0]           ls;
   logic [SPEED_W-1:0]           rs;

   // median below threshold exactly when a majority of the history is below it
   always_comb begin
      for (int s = 0; s < NSENS; s++) begin
         cnt[s] = '0;
         for (int j = 0; j < DEPTH; j++) begin
            cnt[s] = cnt[s] + CNT_W'(CMP_W'(hist_ff[s][j]) < CMP_W'(cfg.threshold));
         end
         mark[s] = (cnt[s] >= CNT_W'(MAJORITY));
      end
   end

   // with neither far sensor marked the weighted sum divided by the count
   // only survives truncation when a single sensor is marked
   always_comb begin
      priority if (mark[SENS_FAR_RIGHT]) begin
         err_in = ERR_FAR_RIGHT;
      end else if (mark[SENS_FAR_LEFT]) begin
         err_in = ERR_FAR_LEFT;
      end else if ($onehot(mark) && mark[SENS_LEFT]) begin
         err_in = ERR_LEFT;
      end else if ($onehot(mark) && mark[SENS_RIGHT]) begin
         err_in = ERR_RIGHT;
      end else begin
         err_in = ERR_NONE;
      end
   end

   assign base_sum = {1'b0, cfg.base_left} + {1'b0, cfg.base_right};

   // |gain * err * sum| / 220 by reciprocal multiply
   always_comb begin
      priority if (err_ff == ERR_FAR_LEFT || err_ff == ERR_FAR_RIGHT) begin
         mag = {prod_ff, 1'b0};
      end else if (err_ff == ERR_LEFT || err_ff == ERR_RIGHT) begin
         mag = {1'b0, prod_ff};
      end else begin
         mag = '0;
      end
   end

   assign scaled = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(DIV_RECIP);

   assign turn_cap = base_sum[SUM_W-1:1];
   assign turn     = (quo_ff > QUO_W'(turn_cap)) ? turn_cap : quo_ff[SPEED_W-1:0];

   always_comb begin
      if (err_ff < 0) begin
         ls_ext = $signed({2'b00, cfg.base_left})  + $signed({2'b00, turn});
         rs_ext = $signed({2'b00, cfg.base_right}) - $signed({2'b00, turn});
      end else begin
         ls_ext = $signed({2'b00, cfg.base_left})  - $signed({2'b00, turn});
         rs_ext = $signed({2'b00, cfg.base_right}) + $signed({2'b00, turn});
      end
      if (lost_ff) begin
         ls = last_err_ff[ERR_W-1] ? SEARCH_SLOW : SEARCH_FAST;
         rs = last_err_ff[ERR_W-1] ? SEARCH_FAST : SEARCH_SLOW;
      end else begin
         ls = sat_speed(ls_ext);
         rs = sat_speed(rs_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSENS; s++) begin
            for (int j = 0; j < DEPTH; j++) begin
               hist_ff[s][j] <= '0;
            end
         end
         slot_ff     <= '0;
         last_err_ff <= ERR_NONE;
      end else begin
         if (cmd.hist_wr) begin
            for (int s = 0; s < NSENS; s++) begin
               hist_ff[s][slot_ff] <= samples[s];
            end
            slot_ff <= (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end
         if (cmd.mark_en && (mark != '0)) begin
            last_err_ff <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mark_en) begin
         err_ff  <= err_in;
         lost_ff <= (mark == '0);
         prod_ff <= PROD_W'(cfg.gain) * PROD_W'(base_sum);
      end
      if (cmd.div_en) begin
         quo_ff <= scaled[MAG_W+RECIP_W-1:DIV_SHIFT];
      end
      if (cmd.out_load) begin
         left_ff     <= ls;
         right_ff    <= rs;
         lost_out_ff <= lost_ff;
         err_out_ff  <= err_ff;
      end
   end

   assign left_speed  = left_ff;
   assign right_speed = right_ff;
   assign line_lost   = lost_out_ff;
   assign steer_error = err_out_ff;
endmodule

// ===== sv/line_follow_steering_top.sv =====
// top level of the line follow steering block
// Each req beat carries one set of five line-sensor samples and yields one rsp
// beat with the two motor duties, the line-lost flag and the position error.
// A beat is written into the per-sensor history on accept, the sensor marks
// and gain times base sum are registered in the mark step, the divide by 220
// runs as one reciprocal multiply in the divide step, and the speeds are
// clamped and saturated into the output register in the finish step; the next
// beat is accepted only once the block is back in idle, so no new beat is taken
// while one is in flight. If the previous result is still unclaimed when the
// finish step is reached, that step waits until rsp takes it. The history lives
// in flip-flops cleared by reset, so no start-up pass is needed. Registers are
// at byte addresses 0 (threshold), 4 (base_left), 8 (base_right) and 12 (gain)
// and are to be written only while the block is idle.
module line_follow_steering_top
   import lfs_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   lfs_req_if.sink               req_bus,
   lfs_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   cfg_type                cfg;
   cmd_type                cmd;
   logic [SAMPLE_BITS-1:0] samples [NSENS];

   assign samples[0] = req_bus.far_left_sample;
   assign samples[1] = req_bus.left_sample;
   assign samples[2] = req_bus.centre_sample;
   assign samples[3] = req_bus.right_sample;
   assign samples[4] = req_bus.far_right_sample;

   lfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   lfs_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .samples     (samples),
      .left_speed  (rsp_bus.left_speed),
      .right_speed (rsp_bus.right_speed),
      .line_lost   (rsp_bus.line_lost),
      .steer_error (rsp_bus.steer_error)
   );
endmodule
